// ----- sv/rfc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfc_pkg
// Shared constants, codes and types for the rake finger combiner.
// ----------------------------------------------------------------------------
package rfc_pkg;

   localparam int PAT_LEN     = 32;
   localparam int DELAY_LIMIT = 63;
   localparam int FINGERS     = 5;
   localparam int HIST_DEPTH  = DELAY_LIMIT + PAT_LEN + 1;

   localparam int SMP_W   = 16;
   localparam int PROD_W  = 2 * SMP_W;
   localparam int FSUM_W  = PROD_W + 6;
   localparam int GAIN_W  = 16;
   localparam int GPROD_W = FSUM_W + GAIN_W;
   localparam int ACC_W   = GPROD_W + 4;
   localparam int OUT_W   = 24;

   localparam int ROUND_SHIFT = SMP_W + 14;

   localparam logic [1:0] OP_SAMPLE  = 2'd0;
   localparam logic [1:0] OP_PATTERN = 2'd1;
   localparam logic [1:0] OP_FINGER  = 2'd2;

   localparam logic signed [SMP_W-1:0] PATTERN_ONE = 16'sd32767;

   typedef struct packed {
      logic                     vld;
      logic                     first;
      logic                     last;
      logic                     final_tap;
      logic signed [GAIN_W-1:0] gain;
   } tap_ctl_type;

endpackage

// ----- sv/rake_finger_combiner.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rake_finger_combiner
// Correlates active rake fingers against a pattern and combines them.
// ----------------------------------------------------------------------------
// The request channel takes one word per item: a sample (op 0), a pattern
// entry write (op 1) or a finger delay and gain write (op 2).
// Table writes are registered on acceptance and give no response word.
// A sample is written into the history, then one complex multiply-accumulate
// unit steps through 32 taps for each active finger, one tap a cycle.
// With no active fingers the block skips the taps and goes to its done state.
// Request ready is low while a sample is being worked on.
// The response word is held in an output register until it is taken; a
// stalled receiver holds the block after its work until the word leaves.
// The csr port sets the active finger count at any idle time.
// Reset clears the history and sets the pattern to one through valid bits,
// zeroes the finger tables, and selects five active fingers.
// ----------------------------------------------------------------------------
module rake_finger_combiner (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_op,
   input  logic signed [15:0]               req_sample_i,
   input  logic signed [15:0]               req_sample_q,
   input  logic [4:0]                       req_pattern_index,
   input  logic signed [15:0]               req_pattern_i,
   input  logic signed [15:0]               req_pattern_q,
   input  logic [2:0]                       req_finger_index,
   input  logic [5:0]                       req_finger_delay,
   input  logic signed [15:0]               req_finger_gain,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [23:0]               rsp_out_i,
   output logic signed [23:0]               rsp_out_q,
   output logic                             rsp_saturated,
   input  logic                             csr_wr_en,
   input  logic [2:0]                       csr_wr_data
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_WAIT = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   localparam int HD = rfc_pkg::HIST_DEPTH;
   localparam int PL = rfc_pkg::PAT_LEN;
   localparam int FN = rfc_pkg::FINGERS;
   localparam int AW = 7;

   logic [1:0]  state_ff, state_in;
   logic [2:0]  active_ff;
   logic [AW-1:0] ptr_ff, newest_ff;
   logic [5:0]  maxd_ff, maxd_w;
   logic [2:0]  nf_ff, nf_w;
   logic [2:0]  f_ff;
   logic [4:0]  j_ff;

   logic [31:0]   hist_mem [HD];
   logic [HD-1:0] hist_vld_ff;
   logic [31:0]   hist_rd_ff;
   logic          hist_rv_ff;
   logic [31:0]   pat_mem [PL];
   logic [PL-1:0] pat_vld_ff;
   logic [31:0]   pat_rd_ff;
   logic          pat_rv_ff;

   logic [5:0]  delay_ff [FN];
   logic signed [15:0] gain_ff [FN];

   logic          accept, tap_last, tap_final;
   logic [AW-1:0] age_w, pos_w;
   logic [AW:0]   pos_wide;
   rfc_pkg::tap_ctl_type tap_ctl_w, tap_ctl_ff;

   logic signed [15:0] smp_i_w, smp_q_w, pat_i_w, pat_q_w;
   logic signed [rfc_pkg::ACC_W-1:0] acc_i, acc_q, rnd_i, rnd_q;
   logic mac_done;
   logic signed [23:0] res_i, res_q;
   logic res_sat_i, res_sat_q;
   logic rsp_valid_ff;
   logic signed [23:0] rsp_i_ff, rsp_q_ff;
   logic rsp_sat_ff;
   logic load_rsp;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      nf_w   = (active_ff > 3'(FN)) ? 3'(FN) : active_ff;
      maxd_w = '0;
      for (int k = 0; k < FN; k++) begin
         if ((3'(k) < nf_w) && (delay_ff[k] > maxd_w)) begin
            maxd_w = delay_ff[k];
         end
      end
   end

   always_comb begin
      age_w    = AW'(maxd_ff) - AW'(delay_ff[f_ff]) + AW'(PL) - AW'(j_ff);
      pos_wide = (newest_ff >= age_w) ? ((AW+1)'(newest_ff) - (AW+1)'(age_w))
                                      : ((AW+1)'(newest_ff) + (AW+1)'(HD) - (AW+1)'(age_w));
      pos_w    = pos_wide[AW-1:0];
      tap_last  = (j_ff == 5'(PL - 1));
      tap_final = tap_last && (f_ff == nf_ff - 3'd1);
      tap_ctl_w.vld       = (state_ff == ST_RUN);
      tap_ctl_w.first     = (j_ff == '0);
      tap_ctl_w.last      = tap_last;
      tap_ctl_w.final_tap = tap_final;
      tap_ctl_w.gain      = gain_ff[f_ff];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_op == rfc_pkg::OP_SAMPLE) begin
               state_in = (nf_w == '0) ? ST_DONE : ST_RUN;
            end
         end
         ST_RUN: begin
            if (tap_final) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (mac_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         active_ff   <= 3'd5;
         ptr_ff      <= '0;
         hist_vld_ff <= '0;
         pat_vld_ff  <= '0;
         f_ff        <= '0;
         j_ff        <= '0;
         for (int k = 0; k < FN; k++) begin
            delay_ff[k] <= '0;
            gain_ff[k]  <= '0;
         end
         tap_ctl_ff.vld       <= 1'b0;
         tap_ctl_ff.first     <= 1'b0;
         tap_ctl_ff.last      <= 1'b0;
         tap_ctl_ff.final_tap <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         tap_ctl_ff <= tap_ctl_w;
         if (csr_wr_en) begin
            active_ff <= csr_wr_data;
         end
         if (accept) begin
            unique case (req_op)
               rfc_pkg::OP_SAMPLE: begin
                  hist_vld_ff[ptr_ff] <= 1'b1;
                  ptr_ff <= (ptr_ff == AW'(HD - 1)) ? '0 : ptr_ff + 1'b1;
                  f_ff   <= '0;
                  j_ff   <= '0;
               end
               rfc_pkg::OP_PATTERN: begin
                  pat_vld_ff[req_pattern_index] <= 1'b1;
               end
               rfc_pkg::OP_FINGER: begin
                  if (req_finger_index < 3'(FN)) begin
                     delay_ff[req_finger_index] <= req_finger_delay;
                     gain_ff[req_finger_index]  <= req_finger_gain;
                  end
               end
               default: ;
            endcase
         end
         if (state_ff == ST_RUN) begin
            j_ff <= j_ff + 1'b1;
            if (tap_last) begin
               f_ff <= f_ff + 1'b1;
            end
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_op == rfc_pkg::OP_SAMPLE) begin
         hist_mem[ptr_ff] <= {req_sample_i, req_sample_q};
         newest_ff <= ptr_ff;
         maxd_ff   <= maxd_w;
         nf_ff     <= nf_w;
      end
      if (accept && req_op == rfc_pkg::OP_PATTERN) begin
         pat_mem[req_pattern_index] <= {req_pattern_i, req_pattern_q};
      end
      hist_rd_ff <= hist_mem[pos_w];
      hist_rv_ff <= hist_vld_ff[pos_w];
      pat_rd_ff  <= pat_mem[j_ff];
      pat_rv_ff  <= pat_vld_ff[j_ff];
      if (load_rsp) begin
         rsp_i_ff   <= res_i;
         rsp_q_ff   <= res_q;
         rsp_sat_ff <= res_sat_i || res_sat_q;
      end
   end

   always_comb begin
      smp_i_w = hist_rv_ff ? $signed(hist_rd_ff[31:16]) : '0;
      smp_q_w = hist_rv_ff ? $signed(hist_rd_ff[15:0])  : '0;
      pat_i_w = pat_rv_ff  ? $signed(pat_rd_ff[31:16])  : rfc_pkg::PATTERN_ONE;
      pat_q_w = pat_rv_ff  ? $signed(pat_rd_ff[15:0])   : '0;
   end

   rfc_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .clear   (accept),
      .tap_ctl (tap_ctl_ff),
      .smp_i   (smp_i_w),
      .smp_q   (smp_q_w),
      .pat_i   (pat_i_w),
      .pat_q   (pat_q_w),
      .acc_i   (acc_i),
      .acc_q   (acc_q),
      .done    (mac_done)
   );

   always_comb begin
      rnd_i = (acc_i + (rfc_pkg::ACC_W'(1) <<< (rfc_pkg::ROUND_SHIFT - 1)))
              >>> rfc_pkg::ROUND_SHIFT;
      rnd_q = (acc_q + (rfc_pkg::ACC_W'(1) <<< (rfc_pkg::ROUND_SHIFT - 1)))
              >>> rfc_pkg::ROUND_SHIFT;
      res_sat_i = 1'b0;
      res_sat_q = 1'b0;
      priority if (rnd_i > rfc_pkg::ACC_W'(24'sh7FFFFF)) begin
         res_i = 24'sh7FFFFF;
         res_sat_i = 1'b1;
      end else if (rnd_i < -rfc_pkg::ACC_W'(25'sh0800000)) begin
         res_i = -24'sh800000;
         res_sat_i = 1'b1;
      end else begin
         res_i = rnd_i[23:0];
      end
      priority if (rnd_q > rfc_pkg::ACC_W'(24'sh7FFFFF)) begin
         res_q = 24'sh7FFFFF;
         res_sat_q = 1'b1;
      end else if (rnd_q < -rfc_pkg::ACC_W'(25'sh0800000)) begin
         res_q = -24'sh800000;
         res_sat_q = 1'b1;
      end else begin
         res_q = rnd_q[23:0];
      end
   end

   assign load_rsp      = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_i     = rsp_i_ff;
   assign rsp_out_q     = rsp_q_ff;
   assign rsp_saturated = rsp_sat_ff;

endmodule

// ----- sv/rfc_mac.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfc_mac
// Shared complex multiply-accumulate unit with finger weighting.
// ----------------------------------------------------------------------------
module rfc_mac (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 clear,
   input  rfc_pkg::tap_ctl_type                 tap_ctl,
   input  logic signed [rfc_pkg::SMP_W-1:0]     smp_i,
   input  logic signed [rfc_pkg::SMP_W-1:0]     smp_q,
   input  logic signed [rfc_pkg::SMP_W-1:0]     pat_i,
   input  logic signed [rfc_pkg::SMP_W-1:0]     pat_q,
   output logic signed [rfc_pkg::ACC_W-1:0]     acc_i,
   output logic signed [rfc_pkg::ACC_W-1:0]     acc_q,
   output logic                                 done
);

   rfc_pkg::tap_ctl_type                  ctl_p_ff;
   logic signed [rfc_pkg::PROD_W-1:0]     p_ac_ff, p_bd_ff, p_bc_ff, p_ad_ff;
   logic signed [rfc_pkg::FSUM_W-1:0]     fsum_i_ff, fsum_q_ff, fsum_i_in, fsum_q_in;
   logic signed [rfc_pkg::FSUM_W-1:0]     fin_i_ff, fin_q_ff;
   logic signed [rfc_pkg::GAIN_W-1:0]     fin_gain_ff;
   logic                                  fin_vld_ff, fin_final_ff;
   logic signed [rfc_pkg::GPROD_W-1:0]    gm_i_ff, gm_q_ff;
   logic                                  gm_vld_ff, gm_final_ff;
   logic signed [rfc_pkg::ACC_W-1:0]      acc_i_ff, acc_q_ff;
   logic                                  done_ff;

   always_comb begin
      fsum_i_in = (ctl_p_ff.first ? '0 : fsum_i_ff)
                + rfc_pkg::FSUM_W'(p_ac_ff) + rfc_pkg::FSUM_W'(p_bd_ff);
      fsum_q_in = (ctl_p_ff.first ? '0 : fsum_q_ff)
                + rfc_pkg::FSUM_W'(p_bc_ff) - rfc_pkg::FSUM_W'(p_ad_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_p_ff.vld       <= 1'b0;
         ctl_p_ff.first     <= 1'b0;
         ctl_p_ff.last      <= 1'b0;
         ctl_p_ff.final_tap <= 1'b0;
         fin_vld_ff         <= 1'b0;
         fin_final_ff       <= 1'b0;
         gm_vld_ff          <= 1'b0;
         gm_final_ff        <= 1'b0;
         done_ff            <= 1'b0;
         acc_i_ff           <= '0;
         acc_q_ff           <= '0;
      end else begin
         ctl_p_ff     <= tap_ctl;
         fin_vld_ff   <= ctl_p_ff.vld && ctl_p_ff.last;
         fin_final_ff <= ctl_p_ff.vld && ctl_p_ff.final_tap;
         gm_vld_ff    <= fin_vld_ff;
         gm_final_ff  <= fin_vld_ff && fin_final_ff;
         done_ff      <= gm_vld_ff && gm_final_ff;
         if (clear) begin
            acc_i_ff <= '0;
            acc_q_ff <= '0;
         end else if (gm_vld_ff) begin
            acc_i_ff <= acc_i_ff + rfc_pkg::ACC_W'(gm_i_ff);
            acc_q_ff <= acc_q_ff + rfc_pkg::ACC_W'(gm_q_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      p_ac_ff <= smp_i * pat_i;
      p_bd_ff <= smp_q * pat_q;
      p_bc_ff <= smp_q * pat_i;
      p_ad_ff <= smp_i * pat_q;
      if (ctl_p_ff.vld) begin
         fsum_i_ff <= fsum_i_in;
         fsum_q_ff <= fsum_q_in;
      end
      if (ctl_p_ff.vld && ctl_p_ff.last) begin
         fin_i_ff    <= fsum_i_in;
         fin_q_ff    <= fsum_q_in;
         fin_gain_ff <= ctl_p_ff.gain;
      end
      gm_i_ff <= fin_i_ff * fin_gain_ff;
      gm_q_ff <= fin_q_ff * fin_gain_ff;
   end

   assign acc_i = acc_i_ff;
   assign acc_q = acc_q_ff;
   assign done  = done_ff;

endmodule

// ----- verif/rake_finger_combiner_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rake_finger_combiner_tb
// Self-checking testbench for the rake finger combiner. Request words are
// drawn from a queue and sent in random bursts. An in-bench model keeps its
// own history, pattern and finger tables and predicts each combined output.
// Response words are taken with random stalls and compared field by field.
// The active finger count is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module rake_finger_combiner_tb;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int         WDOG_LIMIT = 5000;
   localparam int         DRAIN_CYCLES = 200;
   localparam longint     OUT_HI = (64'sd1 <<< (rfc_pkg::OUT_W - 1)) - 1;
   localparam longint     OUT_LO = -(64'sd1 <<< (rfc_pkg::OUT_W - 1));

   typedef struct {
      logic [1:0]         op;
      logic signed [15:0] smp_i;
      logic signed [15:0] smp_q;
      logic [4:0]         pat_idx;
      logic signed [15:0] pat_i;
      logic signed [15:0] pat_q;
      logic [2:0]         fng_idx;
      logic [5:0]         fng_delay;
      logic signed [15:0] fng_gain;
   } req_word_type;

   typedef struct {
      logic signed [23:0] out_i;
      logic signed [23:0] out_q;
      logic               sat;
   } rsp_word_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_op = '0;
   logic signed [15:0] req_sample_i = '0;
   logic signed [15:0] req_sample_q = '0;
   logic [4:0]         req_pattern_index = '0;
   logic signed [15:0] req_pattern_i = '0;
   logic signed [15:0] req_pattern_q = '0;
   logic [2:0]         req_finger_index = '0;
   logic [5:0]         req_finger_delay = '0;
   logic signed [15:0] req_finger_gain = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [23:0] rsp_out_i;
   logic signed [23:0] rsp_out_q;
   logic               rsp_saturated;
   logic               csr_wr_en = 1'b0;
   logic [2:0]         csr_wr_data = '0;

   rake_finger_combiner dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_sample_i      (req_sample_i),
      .req_sample_q      (req_sample_q),
      .req_pattern_index (req_pattern_index),
      .req_pattern_i     (req_pattern_i),
      .req_pattern_q     (req_pattern_q),
      .req_finger_index  (req_finger_index),
      .req_finger_delay  (req_finger_delay),
      .req_finger_gain   (req_finger_gain),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_i         (rsp_out_i),
      .rsp_out_q         (rsp_out_q),
      .rsp_saturated     (rsp_saturated),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   always #4 clock = ~clock;

   // Combiner model state.
   logic signed [15:0] hist_i [rfc_pkg::HIST_DEPTH];
   logic signed [15:0] hist_q [rfc_pkg::HIST_DEPTH];
   int                 hist_wr;
   logic signed [15:0] pat_tab_i [rfc_pkg::PAT_LEN];
   logic signed [15:0] pat_tab_q [rfc_pkg::PAT_LEN];
   logic [5:0]         delay_tab [rfc_pkg::FINGERS];
   logic signed [15:0] gain_tab [rfc_pkg::FINGERS];
   logic [2:0]         active_cnt;

   req_word_type pending_words [$];
   rsp_word_type expected_rsp [$];
   req_word_type cur_word;
   int           error_count = 0;
   int           idle_cycles = 0;

   task automatic report(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic model_reset();
      for (int k = 0; k < rfc_pkg::HIST_DEPTH; k++) begin
         hist_i[k] = '0;
         hist_q[k] = '0;
      end
      hist_wr = 0;
      for (int k = 0; k < rfc_pkg::PAT_LEN; k++) begin
         pat_tab_i[k] = rfc_pkg::PATTERN_ONE;
         pat_tab_q[k] = '0;
      end
      for (int k = 0; k < rfc_pkg::FINGERS; k++) begin
         delay_tab[k] = '0;
         gain_tab[k] = '0;
      end
      active_cnt = 3'd5;
   endtask

   function automatic longint round_clip(input longint acc, inout logic sat);
      longint r;
      r = (acc + (64'sd1 <<< (rfc_pkg::ROUND_SHIFT - 1))) >>> rfc_pkg::ROUND_SHIFT;
      if (r > OUT_HI) begin
         sat = 1'b1;
         r = OUT_HI;
      end else if (r < OUT_LO) begin
         sat = 1'b1;
         r = OUT_LO;
      end
      return r;
   endfunction

   task automatic apply_word(input req_word_type w);
      int           newest, nf, maxd, age, pos;
      longint       acc_i, acc_q, fi, fq, a, b, c, d;
      rsp_word_type r;
      case (w.op)
         rfc_pkg::OP_PATTERN: begin
            pat_tab_i[w.pat_idx] = w.pat_i;
            pat_tab_q[w.pat_idx] = w.pat_q;
         end
         rfc_pkg::OP_FINGER: begin
            if (w.fng_idx < rfc_pkg::FINGERS) begin
               delay_tab[w.fng_idx] = (w.fng_delay > 6'(rfc_pkg::DELAY_LIMIT)) ?
                                      6'(rfc_pkg::DELAY_LIMIT) : w.fng_delay;
               gain_tab[w.fng_idx] = w.fng_gain;
            end
         end
         rfc_pkg::OP_SAMPLE: begin
            newest = hist_wr;
            hist_i[newest] = w.smp_i;
            hist_q[newest] = w.smp_q;
            hist_wr = (newest + 1) % rfc_pkg::HIST_DEPTH;
            nf = (active_cnt > rfc_pkg::FINGERS) ? rfc_pkg::FINGERS : active_cnt;
            maxd = 0;
            for (int f = 0; f < nf; f++)
               if (delay_tab[f] > maxd) maxd = delay_tab[f];
            acc_i = 0;
            acc_q = 0;
            for (int f = 0; f < nf; f++) begin
               fi = 0;
               fq = 0;
               for (int j = 0; j < rfc_pkg::PAT_LEN; j++) begin
                  age = maxd - delay_tab[f] + rfc_pkg::PAT_LEN - j;
                  pos = (newest + rfc_pkg::HIST_DEPTH - (age % rfc_pkg::HIST_DEPTH))
                        % rfc_pkg::HIST_DEPTH;
                  a = hist_i[pos];
                  b = hist_q[pos];
                  c = pat_tab_i[j];
                  d = pat_tab_q[j];
                  fi += a * c + b * d;
                  fq += b * c - a * d;
               end
               acc_i += fi * longint'(gain_tab[f]);
               acc_q += fq * longint'(gain_tab[f]);
            end
            r.sat = 1'b0;
            r.out_i = 24'(round_clip(acc_i, r.sat));
            r.out_q = 24'(round_clip(acc_q, r.sat));
            expected_rsp.push_back(r);
         end
         default: ;
      endcase
   endtask

   // Driver.
   always @(posedge clock) begin : drive_req
      int           burst_left;
      int           gap_left;
      req_word_type w;
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else begin
         if (req_valid && req_ready) apply_word(cur_word);
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
               w = pending_words.pop_front();
               cur_word = w;
               req_op <= w.op;
               req_sample_i <= w.smp_i;
               req_sample_q <= w.smp_q;
               req_pattern_index <= w.pat_idx;
               req_pattern_i <= w.pat_i;
               req_pattern_q <= w.pat_q;
               req_finger_index <= w.fng_idx;
               req_finger_delay <= w.fng_delay;
               req_finger_gain <= w.fng_gain;
               req_valid <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 12);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor and receiver stall pattern.
   always @(posedge clock) begin : watch_rsp
      int           stall_left;
      rsp_word_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               report("response word with none expected");
            end else begin
               e = expected_rsp.pop_front();
               if (rsp_out_i !== e.out_i)
                  report($sformatf("out_i %0d, expected %0d", rsp_out_i, e.out_i));
               if (rsp_out_q !== e.out_q)
                  report($sformatf("out_q %0d, expected %0d", rsp_out_q, e.out_q));
               if (rsp_saturated !== e.sat)
                  report($sformatf("saturated %0b, expected %0b", rsp_saturated, e.sat));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 40);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic signed [15:0] rand_val();
      case ($urandom_range(0, 7))
         0: return -16'sd32768;
         1: return 16'sd32767;
         2: return 16'(signed'($urandom_range(0, 64)) - 32);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic req_word_type blank_word(input logic [1:0] op);
      req_word_type w;
      w.op = op;
      w.smp_i = 16'($urandom);
      w.smp_q = 16'($urandom);
      w.pat_idx = 5'($urandom);
      w.pat_i = 16'($urandom);
      w.pat_q = 16'($urandom);
      w.fng_idx = 3'($urandom);
      w.fng_delay = 6'($urandom);
      w.fng_gain = 16'($urandom);
      return w;
   endfunction

   task automatic push_sample(input logic signed [15:0] si, input logic signed [15:0] sq);
      req_word_type w;
      w = blank_word(rfc_pkg::OP_SAMPLE);
      w.smp_i = si;
      w.smp_q = sq;
      pending_words.push_back(w);
   endtask

   task automatic push_pattern(input int idx, input logic signed [15:0] pi,
                               input logic signed [15:0] pq);
      req_word_type w;
      w = blank_word(rfc_pkg::OP_PATTERN);
      w.pat_idx = 5'(idx);
      w.pat_i = pi;
      w.pat_q = pq;
      pending_words.push_back(w);
   endtask

   task automatic push_finger(input int idx, input int dly, input logic signed [15:0] g);
      req_word_type w;
      w = blank_word(rfc_pkg::OP_FINGER);
      w.fng_idx = 3'(idx);
      w.fng_delay = 6'(dly);
      w.fng_gain = g;
      pending_words.push_back(w);
   endtask

   task automatic wait_idle();
      do
         @(negedge clock);
      while (pending_words.size() != 0 || req_valid || expected_rsp.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_fingers(input logic [2:0] v);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      active_cnt = v;
   endtask

   task automatic random_phase(input int n_items);
      int           pick;
      req_word_type w;
      if ($urandom_range(0, 2) == 0)
         for (int k = 0; k < rfc_pkg::PAT_LEN; k++) push_pattern(k, rand_val(), rand_val());
      for (int f = 0; f < rfc_pkg::FINGERS; f++)
         push_finger(f, $urandom_range(0, 63), rand_val());
      for (int k = 0; k < n_items; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            push_sample(rand_val(), rand_val());
         end else if (pick < 80) begin
            push_pattern($urandom_range(0, 31), rand_val(), rand_val());
         end else if (pick < 95) begin
            push_finger($urandom_range(0, 7), $urandom_range(0, 63), rand_val());
         end else begin
            w = blank_word(OP_UNUSED);
            pending_words.push_back(w);
         end
      end
   endtask

   initial begin
      logic [2:0]   phase_fingers [9];
      req_word_type w;
      phase_fingers = '{3'd1, 3'd0, 3'd7, 3'd3, 3'd6, 3'd5, 3'd2, 3'd4, 3'd5};
      model_reset();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      write_fingers(3'd5);

      push_sample(16'sd32767, -16'sd32768);
      push_pattern(0, -16'sd32768, 16'sd32767);
      push_pattern(31, 16'sd32767, -16'sd32768);
      push_finger(0, 0, 16'sd32767);
      push_finger(1, 63, -16'sd32768);
      push_finger(2, 5, 16'sd4096);
      push_finger(3, 17, -16'sd4096);
      push_finger(4, 63, 16'sd1);
      push_finger(7, 9, 16'sd1234);
      push_finger(5, 9, 16'sd1234);
      w = blank_word(OP_UNUSED);
      pending_words.push_back(w);
      push_sample(-16'sd32768, -16'sd32768);
      push_sample(16'sd32767, 16'sd32767);
      push_sample(16'sd0, 16'sd0);
      push_sample(-16'sd1, 16'sd1);
      for (int k = 0; k < 8; k++) push_sample(-16'sd32768, 16'sd32767);
      wait_idle();

      // Every tap and finger lined up at full scale drives the output into clipping.
      for (int k = 0; k < rfc_pkg::PAT_LEN; k++) push_pattern(k, -16'sd32768, -16'sd32768);
      for (int f = 0; f < rfc_pkg::FINGERS; f++) push_finger(f, 0, -16'sd32768);
      for (int k = 0; k < 40; k++) push_sample(-16'sd32768, -16'sd32768);
      for (int k = 0; k < 4; k++) push_sample(16'sd32767, 16'sd32767);
      wait_idle();

      foreach (phase_fingers[p]) begin
         write_fingers(phase_fingers[p]);
         random_phase(110);
         wait_idle();
      end

      if (expected_rsp.size() != 0) report("expected response words left over");
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
